[rtl/preemptive_priority_scheduler_top_assert.svh]
// Assertion macros for the preemptive priority scheduler.
// Included by the top level; needs nothing else.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication under reset
`define PPSCH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define PPSCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppsch_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
// No dependencies.
package ppsch_pkg;

  localparam int unsigned SLOTS_DEF  = 16;
  localparam logic [9:0]  PRIO_LIMIT = 10'd999;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  slot;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [9:0]  priority_req;
  } in_req_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        idle;
    logic [3:0]  running_slot;
    logic        switched;
    logic        finished;
    logic [15:0] completion_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
    logic [19:0] total_turnaround;
    logic [19:0] total_waiting;
  } out_rsp_t;

  // one task table entry, held by one cell of the ring
  typedef struct packed {
    logic        loaded;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [9:0]  prio;
  } entry_t;

endpackage

[rtl/preemptive_priority_scheduler_top.sv]
// Preemptive priority scheduler top level: ring of task cells, scan head, totals.
// Depends on ppsch_pkg, ppsch_cell and preemptive_priority_scheduler_top_assert.svh.
//
//   channel | signals                          | carries
//   in      | in_valid_i, in_stall_o, in_req_i | load entry or time tick
//   out     | out_valid_o, out_stall_i, out_rsp_o | one result per tick
//
// A load is written straight into its cell. During a tick the ring rotates once past
// the compare head, then the result is committed to the output register.
// The commit waits while a previous result is still stalled in the output register.
// Reset clears loaded flags, counters, time, totals and the runner mark; entry
// contents are undefined until loaded.
module preemptive_priority_scheduler_top
  import ppsch_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned MARK_W = $clog2(SLOTS + 2);
  localparam logic [MARK_W-1:0] MARK_IDLE = MARK_W'(SLOTS);
  localparam logic [MARK_W-1:0] MARK_NONE = MARK_W'(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;

  entry_t cells [SLOTS];

  // scan head
  logic              best_found_q, best_found_d;
  logic [SLOT_W-1:0] best_idx_q, best_idx_d;
  logic [9:0]        best_prio_q, best_prio_d;
  logic [15:0]       best_arr_q, best_arr_d;
  logic [15:0]       best_burst_q, best_burst_d;
  logic [15:0]       best_rem_q, best_rem_d;

  logic [CNT_W-1:0]  loaded_cnt_q, loaded_cnt_d;
  logic [CNT_W-1:0]  fin_cnt_q, fin_cnt_d;
  logic [15:0]       time_q, time_d;
  logic [MARK_W-1:0] prev_mark_q, prev_mark_d;
  logic [19:0]       sum_tat_q, sum_tat_d;
  logic [19:0]       sum_wt_q, sum_wt_d;

  logic     out_valid_q, out_valid_d;
  out_rsp_t out_q, out_d;

  logic accept, load_go, tick_go, shift, commit, load_ok;
  logic [SLOT_W-1:0] ls;
  entry_t load_data, head, tgt;
  logic head_elig, head_better;
  logic [MARK_W-1:0] mark;
  logic fin;
  logic [15:0] ct, tat, wt;
  logic [20:0] tat_sum, wt_sum;

  assign accept  = in_valid_i && !in_stall_o;
  assign load_ok = (32'(in_req_i.slot) < SLOTS);
  assign ls      = SLOT_W'(in_req_i.slot);
  assign load_go = accept && (in_req_i.func == FUNC_LOAD) && load_ok;
  assign tick_go = accept && (in_req_i.func == FUNC_TICK);
  assign shift   = (state_q == ST_SCAN);
  assign commit  = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign load_data = '{loaded: 1'b1, arrival: in_req_i.arrival, burst: in_req_i.burst,
                       remaining: in_req_i.burst, prio: in_req_i.priority_req};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ppsch_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .nbr_i       (cells[(i + 1) % SLOTS]),
      .load_i      (load_go && (ls == SLOT_W'(i))),
      .load_data_i (load_data),
      .dec_i       (commit && best_found_q && (best_idx_q == SLOT_W'(i))),
      .entry_o     (cells[i])
    );
  end

  // cell 0 always holds the slot numbered by cnt_q during the scan
  assign head      = cells[0];
  assign head_elig = head.loaded && (head.remaining != 16'd0) && (head.arrival <= time_q);
  assign head_better = head_elig &&
                       ((head.prio < best_prio_q) ||
                        (best_found_q && head.prio == best_prio_q &&
                         head.arrival < best_arr_q));

  assign tgt = cells[ls];

  // commit arithmetic
  assign mark    = best_found_q ? MARK_W'(best_idx_q) : MARK_IDLE;
  assign fin     = best_found_q && (best_rem_q == 16'd1);
  assign ct      = fin ? time_q + 16'd1 : 16'd0;
  assign tat     = fin ? ct - best_arr_q : 16'd0;
  assign wt      = fin ? tat - best_burst_q : 16'd0;
  assign tat_sum = {1'b0, sum_tat_q} + 21'(tat);
  assign wt_sum  = {1'b0, sum_wt_q} + 21'(wt);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_prio_d  = best_prio_q;
    best_arr_d   = best_arr_q;
    best_burst_d = best_burst_q;
    best_rem_d   = best_rem_q;
    loaded_cnt_d = loaded_cnt_q;
    fin_cnt_d    = fin_cnt_q;
    time_d       = time_q;
    prev_mark_d  = prev_mark_q;
    sum_tat_d    = sum_tat_q;
    sum_wt_d     = sum_wt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    if (load_go) begin
      // reload of a finished entry takes it back out of the finished count
      if (tgt.loaded) begin
        if (tgt.remaining == 16'd0) fin_cnt_d = fin_cnt_d - CNT_W'(1);
      end else begin
        loaded_cnt_d = loaded_cnt_q + CNT_W'(1);
      end
      if (in_req_i.burst == 16'd0) fin_cnt_d = fin_cnt_d + CNT_W'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (tick_go) begin
          state_d      = ST_SCAN;
          cnt_d        = '0;
          best_found_d = 1'b0;
          best_prio_d  = PRIO_LIMIT;
          best_idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (head_better) begin
          best_found_d = 1'b1;
          best_idx_d   = cnt_q;
          best_prio_d  = head.prio;
          best_arr_d   = head.arrival;
          best_burst_d = head.burst;
          best_rem_d   = head.remaining;
        end
        cnt_d = cnt_q + SLOT_W'(1);
        if (cnt_q == SLOT_W'(SLOTS - 1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (commit) begin
          state_d     = ST_IDLE;
          prev_mark_d = mark;
          time_d      = time_q + 16'd1;
          if (fin) begin
            fin_cnt_d = fin_cnt_q + CNT_W'(1);
            sum_tat_d = tat_sum[20] ? '1 : tat_sum[19:0];
            sum_wt_d  = wt_sum[20] ? '1 : wt_sum[19:0];
          end
          out_valid_d            = 1'b1;
          out_d.tick_time        = time_q;
          out_d.idle             = !best_found_q;
          out_d.running_slot     = best_found_q ? 4'(best_idx_q) : 4'd0;
          out_d.switched         = (mark != prev_mark_q);
          out_d.finished         = fin;
          out_d.completion_time  = ct;
          out_d.turnaround       = tat;
          out_d.waiting          = wt;
          out_d.all_done         = (fin_cnt_d == loaded_cnt_q);
          out_d.total_turnaround = sum_tat_d;
          out_d.total_waiting    = sum_wt_d;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      best_found_q <= 1'b0;
      loaded_cnt_q <= '0;
      fin_cnt_q    <= '0;
      time_q       <= '0;
      prev_mark_q  <= MARK_NONE;
      sum_tat_q    <= '0;
      sum_wt_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      best_found_q <= best_found_d;
      loaded_cnt_q <= loaded_cnt_d;
      fin_cnt_q    <= fin_cnt_d;
      time_q       <= time_d;
      prev_mark_q  <= prev_mark_d;
      sum_tat_q    <= sum_tat_d;
      sum_wt_q     <= sum_wt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_arr_q   <= best_arr_d;
    best_burst_q <= best_burst_d;
    best_rem_q   <= best_rem_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`include "preemptive_priority_scheduler_top_assert.svh"

  `PPSCH_ASSERT_NOW(a_rise_from_fin, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == ST_FIN), "result without commit")
  `PPSCH_ASSERT_NOW(a_fin_le_loaded, clk_i, rst_ni, 1'b1, fin_cnt_q <= loaded_cnt_q, "finished count exceeds loaded count")
  `PPSCH_ASSERT_NEXT(a_scan_steps, clk_i, rst_ni, state_q == ST_SCAN && cnt_q != SLOT_W'(SLOTS - 1), state_q == ST_SCAN && cnt_q == $past(cnt_q) + SLOT_W'(1), "scan counter skipped")
  `PPSCH_ASSERT_NOW(a_fin_not_idle, clk_i, rst_ni, out_valid_o && out_rsp_o.finished, !out_rsp_o.idle, "finish reported on idle tick")

endmodule

[rtl/ppsch_cell.sv]
// One cell of the task ring: holds one entry, rotates it to its neighbor on shift.
// Depends on ppsch_pkg.
module ppsch_cell
  import ppsch_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t nbr_i,
  input  logic   load_i,
  input  entry_t load_data_i,
  input  logic   dec_i,
  output entry_t entry_o
);

  logic        loaded_q;
  logic [15:0] arrival_q, burst_q, remaining_q;
  logic [9:0]  prio_q;
  entry_t      entry_cur, entry_d;

  assign entry_cur = '{loaded: loaded_q, arrival: arrival_q, burst: burst_q,
                       remaining: remaining_q, prio: prio_q};

  always_comb begin
    entry_d = entry_cur;
    priority if (load_i) begin
      entry_d = load_data_i;
    end else if (dec_i) begin
      entry_d.remaining = entry_cur.remaining - 16'd1;
    end else if (shift_i) begin
      entry_d = nbr_i;
    end
  end

  // only the loaded flag needs a reset; payload is don't-care until loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else begin
      loaded_q <= entry_d.loaded;
    end
  end

  always_ff @(posedge clk_i) begin
    arrival_q   <= entry_d.arrival;
    burst_q     <= entry_d.burst;
    remaining_q <= entry_d.remaining;
    prio_q      <= entry_d.prio;
  end

  assign entry_o = entry_cur;

endmodule
